// ----- hw/rtl/ffmta_pkg.sv -----
`default_nettype none

package ffmta_pkg;

  localparam int CAP_W  = 30;
  localparam int SLOT_W = 10;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Exactly one of these is raised in any cycle, or none.
  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic check;
    logic desc;
    logic leaf;
    logic load_wr;
    logic up;
    logic emit;
  } ffmta_cmd_t;

  typedef struct packed {
    logic item_op;
    logic op;
    logic slot_ok;
    logic root_ok;
    logic desc_leaf;
    logic up_last;
    logic clr_last;
    logic out_free;
  } ffmta_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ffmta_ctrl.sv -----
`default_nettype none

module ffmta_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  ffmta_pkg::ffmta_status_t status,
  output ffmta_pkg::ffmta_cmd_t    cmd
);
  import ffmta_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_LOAD  = 8'b0000_0100,
    ST_CHECK = 8'b0000_1000,
    ST_DESC  = 8'b0001_0000,
    ST_LEAF  = 8'b0010_0000,
    ST_UP    = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = (status.item_op == OP_REQUEST) ? ST_CHECK : ST_LOAD;
        end
      end
      ST_LOAD: begin
        // A load beyond the last slot is dropped without touching the tree.
        if (status.slot_ok) begin
          cmd.load_wr = 1'b1;
          state_next  = ST_UP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.root_ok ? ST_DESC : ST_DONE;
      end
      ST_DESC: begin
        cmd.desc = 1'b1;
        if (status.desc_leaf) begin
          state_next = ST_LEAF;
        end
      end
      ST_LEAF: begin
        cmd.leaf   = 1'b1;
        state_next = ST_UP;
      end
      ST_UP: begin
        cmd.up = 1'b1;
        if (status.up_last) begin
          state_next = (status.op == OP_REQUEST) ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ffmta_dpath.sv -----
`default_nettype none

module ffmta_dpath #(
  parameter int SLOTS  = 1024,
  parameter int LEVELS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ffmta_pkg::ffmta_cmd_t          cmd,
  output ffmta_pkg::ffmta_status_t       status,
  input  logic                           opcode,
  input  logic [ffmta_pkg::SLOT_W-1:0]   slot_index,
  input  logic [ffmta_pkg::CAP_W-1:0]    amount,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           found,
  output logic [ffmta_pkg::SLOT_W-1:0]   granted_slot,
  output logic [ffmta_pkg::CAP_W-1:0]    remaining
);
  import ffmta_pkg::*;

  localparam int ADDR_W = LEVELS + 1;
  localparam int NODES  = 2 ** ADDR_W;

  // Heap-numbered max tree; node 0 is unused and the leaves sit at the top half.
  logic [CAP_W-1:0]  mem [NODES];
  logic [CAP_W-1:0]  rdata;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CAP_W-1:0]  wr_data;
  logic [ADDR_W-1:0] rd_addr;

  logic              op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CAP_W-1:0]  amt_q;
  logic [ADDR_W-1:0] node;
  logic [CAP_W-1:0]  cur;
  logic              found_q;
  logic [LEVELS-1:0] slot_res;
  logic [CAP_W-1:0]  rem_q;

  logic              left_ok;
  logic [ADDR_W-1:0] node_desc;
  logic [ADDR_W-1:0] parent;
  logic [ADDR_W-1:0] leaf_addr;
  logic [CAP_W-1:0]  up_max;
  logic [CAP_W-1:0]  leaf_new;

  assign left_ok   = (rdata >= amt_q);
  assign node_desc = {node[LEVELS-1:0], ~left_ok};
  assign parent    = {1'b0, node[ADDR_W-1:1]};
  assign leaf_addr = {1'b1, LEVELS'(slot_q)};
  assign up_max    = (cur > rdata) ? cur : rdata;
  assign leaf_new  = rdata - amt_q;

  assign status.item_op   = opcode;
  assign status.op        = op_q;
  assign status.slot_ok   = (32'(slot_q) < 32'(SLOTS));
  assign status.root_ok   = (rdata >= amt_q);
  assign status.desc_leaf = node[LEVELS-1];
  assign status.up_last   = (parent == ADDR_W'(1));
  assign status.clr_last  = &node;
  assign status.out_free  = !result_valid || !result_stall;

  // The read port fetches the next node on the path while the write port
  // stores the one just computed (at the leaf, on a load and on the way up).
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = '0;
    rd_addr = ADDR_W'(1);
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.check) begin
      rd_addr = ADDR_W'(2);
    end else if (cmd.desc) begin
      rd_addr = status.desc_leaf ? node_desc : {node_desc[LEVELS-1:0], 1'b0};
    end else if (cmd.leaf) begin
      wr_en   = 1'b1;
      wr_data = leaf_new;
      rd_addr = node ^ ADDR_W'(1);
    end else if (cmd.load_wr) begin
      wr_en   = 1'b1;
      wr_addr = leaf_addr;
      wr_data = amt_q;
      rd_addr = leaf_addr ^ ADDR_W'(1);
    end else if (cmd.up) begin
      wr_en   = 1'b1;
      wr_addr = parent;
      wr_data = up_max;
      rd_addr = parent ^ ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        node <= node + ADDR_W'(1);
      end else if (cmd.check) begin
        node <= ADDR_W'(1);
      end else if (cmd.desc) begin
        node <= node_desc;
      end else if (cmd.load_wr) begin
        node <= leaf_addr;
      end else if (cmd.up) begin
        node <= parent;
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= opcode;
      slot_q <= slot_index;
      amt_q  <= amount;
    end
    if (cmd.check) begin
      found_q <= status.root_ok;
    end
    if (cmd.leaf) begin
      cur      <= leaf_new;
      rem_q    <= leaf_new;
      slot_res <= node[LEVELS-1:0];
    end else if (cmd.load_wr) begin
      cur <= amt_q;
    end else if (cmd.up) begin
      cur <= up_max;
    end
    if (cmd.emit) begin
      found        <= found_q;
      granted_slot <= found_q ? SLOT_W'(slot_res) : '0;
      remaining    <= found_q ? rem_q : '0;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("controller raised more than one datapath command");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result_valid || !result_stall))
    else $error("result loaded over a beat that was not taken");

  a_leaf_covers: assert property (@(posedge clk) disable iff (rst)
    cmd.leaf |-> (rdata >= amt_q))
    else $error("descent ended on a slot that cannot cover the amount");

  a_desc_inner: assert property (@(posedge clk) disable iff (rst)
    cmd.desc |-> !node[LEVELS])
    else $error("descent continued below the leaf level");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

// ----- hw/rtl/first_fit_max_tree_allocator.sv -----
// With L = clog2(SLOTS) tree levels (L = 10 for 1024 slots):
// a request is served by one node read per level down and one read-write per
// level up through the tree memory's single read port; a load walks only up,
// and a refused request skips the tree walk. The next item is taken only after
// the current one is done and, for a request, its result has been loaded.
// After reset the tree memory is cleared one node per cycle, 2^(L+1) nodes.
`default_nettype none

module first_fit_max_tree_allocator #(
  parameter int SLOTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         opcode,
  input  logic [ffmta_pkg::SLOT_W-1:0] slot_index,
  input  logic [ffmta_pkg::CAP_W-1:0]  amount,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         found,
  output logic [ffmta_pkg::SLOT_W-1:0] granted_slot,
  output logic [ffmta_pkg::CAP_W-1:0]  remaining
);
  import ffmta_pkg::*;

  localparam int LEVELS = $clog2(SLOTS);

  ffmta_cmd_t    cmd;
  ffmta_status_t status;

  ffmta_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  ffmta_dpath #(
    .SLOTS  (SLOTS),
    .LEVELS (LEVELS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .opcode       (opcode),
    .slot_index   (slot_index),
    .amount       (amount),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found),
    .granted_slot (granted_slot),
    .remaining    (remaining)
  );

endmodule

`default_nettype wire
